// ----- rtl/twd_pkg.sv -----
// Package for the tachometer window deviation core.
// Holds widths, reset values and register indexes; no dependencies.
package twd_pkg;
    localparam int WIDTH_W    = 24;
    localparam int RPM_W      = 16;
    localparam int DEV_W      = 18;
    localparam int LIMIT_W    = 16;
    localparam int DEFAULT_DEPTH = 5;
    localparam logic [25:0] RPM_NUMERATOR = 26'd60000000;
    localparam logic [RPM_W-1:0] RPM_MAX = 16'hFFFF;
    localparam logic [WIDTH_W-1:0] TIMEOUT_RESET = 24'd3500000;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd60;
    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_LIMIT   = 1'b1;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_DIV    = 8'b0000_0010,
        ST_UPDATE = 8'b0000_0100,
        ST_MEAN   = 8'b0000_1000,
        ST_VAR    = 8'b0001_0000,
        ST_SQRT   = 8'b0010_0000,
        ST_DIR    = 8'b0100_0000,
        ST_OUT    = 8'b1000_0000
    } t_state;
endpackage

// ----- rtl/tachometer_window_deviation_core.sv -----
// Tachometer window deviation core: speed, window deviation and warning.
// Steps from input transfer to valid result: divide, update, mean, variance,
// square root, direction, output; the divide is skipped when both widths are
// zero, since no division is needed.
// A new input is taken only once the last result has been transferred.
// Reset (synchronous, active low) clears the window, sum, slot and registers.
module tachometer_window_deviation_core #(
    parameter int WINDOW_DEPTH = twd_pkg::DEFAULT_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // high_width[23:0], low_width[47:24]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // speed_rpm[15:0], deviation[33:16], pad
    output logic        m_axis_tuser,   // warning
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [23:0] i_cfg_data
);
    localparam int SUM_W  = twd_pkg::RPM_W + $clog2(WINDOW_DEPTH);
    localparam int IDX_W  = $clog2(WINDOW_DEPTH);
    localparam int VAR_W  = 2 * twd_pkg::RPM_W + $clog2(WINDOW_DEPTH);
    localparam int SQ_W   = (VAR_W + 1) / 2;
    localparam int NUM_W  = 26;
    localparam int DEN_W  = 26;
    // The mean is a multiplication by a rounded-up reciprocal of the depth,
    // exact for every sum that fits in SUM_W bits.
    localparam int SHIFT_W = SUM_W + IDX_W;
    localparam logic [SHIFT_W:0] RECIP = (SHIFT_W+1)'(((64'd1 << SHIFT_W)
        + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH));

    twd_pkg::t_state r_state;
    logic [twd_pkg::WIDTH_W-1:0] r_timeout;
    logic [twd_pkg::LIMIT_W-1:0] r_limit;
    logic [twd_pkg::RPM_W-1:0]   r_win [WINDOW_DEPTH];
    logic [IDX_W-1:0]            r_slot, r_idx;
    logic [SUM_W-1:0]            r_sum;
    logic [twd_pkg::RPM_W-1:0]   r_rpm, r_mean;
    logic [VAR_W-1:0]            r_var;
    logic [VAR_W+1:0]            r_root, r_bit;
    logic                        r_up, r_down;
    logic                        r_div_start;
    logic [NUM_W-1:0]            r_div_num;
    logic [DEN_W-1:0]            r_div_den;
    logic                        w_div_done;
    logic [NUM_W-1:0]            w_div_quot;
    logic [twd_pkg::RPM_W-1:0]   r_o_rpm;
    logic [twd_pkg::DEV_W-1:0]   r_o_dev;
    logic                        r_o_warn, r_o_valid;
    logic [twd_pkg::WIDTH_W-1:0] w_hi, w_lo;
    logic [twd_pkg::RPM_W-1:0]   w_cur, w_nxt, w_d;
    logic [2*twd_pkg::RPM_W-1:0] w_sq;
    logic [SUM_W+SHIFT_W:0]      w_mean_prod;
    logic [IDX_W-1:0]            w_inx, w_slot_nx;
    logic [VAR_W+1:0]            w_rb;

    assign w_hi = s_axis_tdata[23:0];
    assign w_lo = s_axis_tdata[47:24];
    assign s_axis_tready = (r_state == twd_pkg::ST_IDLE) && !r_o_valid;
    assign o_cfg_ready = 1'b1;

    twd_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_div_start),
        .i_num(r_div_num), .i_den(r_div_den),
        .o_done(w_div_done), .o_quot(w_div_quot)
    );

    // Shared pieces for the walks over the window, plus mean, root and slot logic.
    assign w_cur = r_win[r_idx];
    assign w_inx = (r_idx == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : r_idx + 1'b1;
    assign w_nxt = r_win[w_inx];
    assign w_d = (w_cur >= r_mean) ? w_cur - r_mean : r_mean - w_cur;
    assign w_sq = w_d * w_d;
    assign w_mean_prod = r_sum * RECIP;
    assign w_rb = r_root + r_bit;
    assign w_slot_nx = (r_slot == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : r_slot + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= twd_pkg::ST_IDLE;
            r_timeout <= twd_pkg::TIMEOUT_RESET;
            r_limit   <= twd_pkg::LIMIT_RESET;
            r_slot    <= '0;
            r_sum     <= '0;
            r_o_valid <= 1'b0;
            r_div_start <= 1'b0;
            for (int i = 0; i < WINDOW_DEPTH; i++) r_win[i] <= '0;
        end else begin
            r_div_start <= 1'b0;
            if (i_cfg_valid) begin
                if (i_cfg_index == twd_pkg::REG_TIMEOUT) r_timeout <= i_cfg_data;
                else r_limit <= i_cfg_data[twd_pkg::LIMIT_W-1:0];
            end
            if (r_o_valid && m_axis_tready) r_o_valid <= 1'b0;
            case (r_state)
                twd_pkg::ST_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        if (w_hi == '0 && w_lo == '0) begin
                            r_rpm   <= '0;
                            r_state <= twd_pkg::ST_UPDATE;
                        end else begin
                            r_div_num <= NUM_W'(twd_pkg::RPM_NUMERATOR);
                            if (w_hi != '0 && w_lo != '0)
                                r_div_den <= DEN_W'(w_hi) + DEN_W'(w_lo);
                            else
                                r_div_den <= DEN_W'(w_hi) + DEN_W'(w_lo)
                                    + DEN_W'(r_timeout);
                            r_div_start  <= 1'b1;
                            r_state      <= twd_pkg::ST_DIV;
                        end
                    end
                end
                twd_pkg::ST_DIV: begin
                    if (w_div_done) begin
                        r_rpm <= (w_div_quot > NUM_W'(twd_pkg::RPM_MAX)) ?
                            twd_pkg::RPM_MAX : w_div_quot[twd_pkg::RPM_W-1:0];
                        r_state <= twd_pkg::ST_UPDATE;
                    end
                end
                twd_pkg::ST_UPDATE: begin
                    r_sum <= r_sum - SUM_W'(r_win[r_slot]) + SUM_W'(r_rpm);
                    r_win[r_slot] <= r_rpm;
                    r_slot  <= w_slot_nx;
                    r_state <= twd_pkg::ST_MEAN;
                end
                twd_pkg::ST_MEAN: begin
                    r_mean  <= w_mean_prod[SHIFT_W +: twd_pkg::RPM_W];
                    r_idx   <= '0;
                    r_var   <= '0;
                    r_state <= twd_pkg::ST_VAR;
                end
                twd_pkg::ST_VAR: begin
                    r_var <= r_var + VAR_W'(w_sq);
                    if (r_idx == IDX_W'(WINDOW_DEPTH - 1)) begin
                        r_root  <= '0;
                        r_bit   <= (VAR_W+2)'(1) << (2 * (SQ_W - 1));
                        r_state <= twd_pkg::ST_SQRT;
                    end else r_idx <= r_idx + 1'b1;
                end
                twd_pkg::ST_SQRT: begin
                    if ((VAR_W+2)'(r_var) >= w_rb) begin
                        r_var  <= VAR_W'((VAR_W+2)'(r_var) - w_rb);
                        r_root <= (r_root >> 1) + r_bit;
                    end else r_root <= r_root >> 1;
                    r_bit <= r_bit >> 2;
                    if (r_bit[1:0] != 2'b00) begin
                        r_idx   <= r_slot;
                        r_up    <= 1'b0;
                        r_down  <= 1'b0;
                        r_state <= twd_pkg::ST_DIR;
                    end
                end
                twd_pkg::ST_DIR: begin
                    if (w_nxt > w_cur) r_up <= 1'b1;
                    else if (w_nxt < w_cur) r_down <= 1'b1;
                    r_idx <= w_inx;
                    if (w_inx == r_slot || (w_inx == (r_slot == '0 ?
                        IDX_W'(WINDOW_DEPTH - 1) : r_slot - 1'b1))) begin
                        r_state <= twd_pkg::ST_OUT;
                    end
                end
                twd_pkg::ST_OUT: begin
                    r_o_rpm   <= r_rpm;
                    r_o_dev   <= twd_pkg::DEV_W'(r_root);
                    r_o_warn  <= (r_root > (VAR_W+2)'(r_limit)) && r_up && r_down;
                    r_o_valid <= 1'b1;
                    r_state   <= twd_pkg::ST_IDLE;
                end
                default: r_state <= twd_pkg::ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {6'd0, r_o_dev, r_o_rpm};
    assign m_axis_tuser  = r_o_warn;
endmodule

// ----- rtl/twd_divider.sv -----
// Restoring shift-subtract divider, one quotient bit per cycle.
// Depends on nothing; used for the speed.
module twd_divider #(
    parameter int NUM_W = 26,
    parameter int DEN_W = 26
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);
    logic [NUM_W-1:0] r_quot, n_quot;
    logic [DEN_W:0]   r_rem, n_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_done;
    logic [DEN_W:0]   w_trial;

    always_comb begin
        w_trial = {r_rem[DEN_W-1:0], r_quot[NUM_W-1]};
        n_quot  = {r_quot[NUM_W-2:0], 1'b0};
        n_rem   = w_trial;
        if (w_trial >= {1'b0, r_den}) begin
            n_rem     = w_trial - {1'b0, r_den};
            n_quot[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
                r_quot <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_quot <= n_quot;
                r_rem  <= n_rem;
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

// ----- rtl/twd_checker.sv -----
// Port-level checker for the tachometer window deviation core.
// Depends on the top level's ports; bound to it below.
module twd_props (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready right after an accepted transfer");
    a_noout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while a result waits");
    a_warn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[33:16] != 18'd0)
        else $error("warning with zero deviation");
endmodule

bind tachometer_window_deviation_core twd_props u_twd_props (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
